FILE: hdl/tccs_pkg.sv
// ----------------------------------------------------------------------------
// Text console package
// Shared field widths, character codes, action codes and the command and
// status bundles between the console controller and its datapath.
// ----------------------------------------------------------------------------
package tccs_pkg;

  localparam int DefColumns  = 80;
  localparam int DefRows     = 25;
  localparam int DefTabWidth = 8;

  localparam int ActionW  = 2;
  localparam int CharW    = 8;
  localparam int ColorW   = 4;
  localparam int ColumnW  = 7;
  localparam int RowW     = 5;
  localparam int CellIdxW = 11;
  localparam int LocW     = 11;
  localparam int CellW    = 16;

  localparam logic [CellW-1:0] BlankCell = 16'h0F20;

  localparam logic [CharW-1:0] CodeBackspace = 8'h08;
  localparam logic [CharW-1:0] CodeTab       = 8'h09;
  localparam logic [CharW-1:0] CodeLineFeed  = 8'h0A;
  localparam logic [CharW-1:0] CodeCarriage  = 8'h0D;
  localparam logic [CharW-1:0] CodePrintLo   = 8'h20;
  localparam logic [CharW-1:0] CodePrintHi   = 8'h7F;

  typedef enum logic [ActionW-1:0] {
    ACT_PUT   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_SET   = 2'd3
  } action_e;

  typedef struct packed {
    logic load;    // capture the transaction fields
    logic exec;    // apply the action to cursor and store
    logic fill;    // write blank at the sweep counter
    logic shift;   // move one cell up a row at the sweep counter
    logic locate;  // compute cursor address and result data
  } dp_cmd_t;

  typedef struct packed {
    action_e action;
    logic    scroll;  // put pushed the cursor past the last row
    logic    last;    // sweep counter is at the final cell
  } dp_sts_t;

endpackage

FILE: hdl/tccs_ctrl.sv
// ----------------------------------------------------------------------------
// Text console controller
// Sequences each transaction through execute, screen sweeps, cursor
// location and the result strobe; runs the clearing pass after reset.
// ----------------------------------------------------------------------------
module tccs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  output tccs_pkg::dp_cmd_t cmd_o,
  input  tccs_pkg::dp_sts_t sts_i
);
  import tccs_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_FILL,
    S_SHIFT,
    S_DRAIN,
    S_LOCATE,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;
  logic   done_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.fill = 1'b1;
        if (sts_i.last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        unique case (sts_i.action) inside
          ACT_PUT:   state_d = sts_i.scroll ? S_SHIFT : S_LOCATE;
          ACT_CLEAR: state_d = S_FILL;
          ACT_READ,
          ACT_SET:   state_d = S_LOCATE;
          default:   state_d = S_LOCATE;
        endcase
      end
      S_FILL: begin
        cmd_o.fill = 1'b1;
        if (sts_i.last) state_d = S_LOCATE;
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = S_LOCATE;
      end
      S_LOCATE: begin
        cmd_o.locate = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
      done_q  <= (state_d == S_DONE);
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;

endmodule

FILE: hdl/tccs_dpath.sv
// ----------------------------------------------------------------------------
// Text console datapath
// Screen store, cursor registers, put-character arithmetic, the sweep
// counter for clear and scroll, and the result registers.
// ----------------------------------------------------------------------------
module tccs_dpath #(
  parameter int COLUMNS   = tccs_pkg::DefColumns,
  parameter int ROWS      = tccs_pkg::DefRows,
  parameter int TAB_WIDTH = tccs_pkg::DefTabWidth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tccs_pkg::dp_cmd_t               cmd_i,
  output tccs_pkg::dp_sts_t               sts_o,
  input  logic [tccs_pkg::ActionW-1:0]    action_i,
  input  logic [tccs_pkg::CharW-1:0]      char_code_i,
  input  logic [tccs_pkg::ColorW-1:0]     back_color_i,
  input  logic [tccs_pkg::ColorW-1:0]     fore_color_i,
  input  logic [tccs_pkg::ColumnW-1:0]    column_i,
  input  logic [tccs_pkg::RowW-1:0]       row_i,
  input  logic [tccs_pkg::CellIdxW-1:0]   cell_index_i,
  output logic [tccs_pkg::LocW-1:0]       cursor_location_o,
  output logic [tccs_pkg::CellW-1:0]      cell_data_o
);
  import tccs_pkg::*;

  localparam int CellCount  = COLUMNS * ROWS;
  localparam int AddrW      = $clog2(CellCount);
  localparam int ColW       = $clog2(COLUMNS);
  localparam int CurRowW    = $clog2(ROWS);
  localparam int TabEntries = 2 ** ColW;
  localparam int ColNW      = $clog2(TabEntries + TAB_WIDTH);
  localparam int RowNW      = $clog2(ROWS + 1);

  // screen store
  logic [CellW-1:0] mem [CellCount];
  logic [CellW-1:0] rd_q;
  logic [AddrW-1:0] rd_addr;
  logic             we;
  logic [AddrW-1:0] wa;
  logic [CellW-1:0] wd;

  // captured transaction
  action_e             act_q;
  logic [CharW-1:0]    code_q;
  logic [ColorW-1:0]   back_q;
  logic [ColorW-1:0]   fore_q;
  logic [ColumnW-1:0]  column_q;
  logic [RowW-1:0]     row_in_q;
  logic [CellIdxW-1:0] idx_q;

  // cursor and results
  logic [ColW-1:0]    col_q;
  logic [CurRowW-1:0] row_q;
  logic [AddrW-1:0]   cur_addr_q;
  logic [CellW-1:0]   cell_data_q;

  // sweep
  logic [AddrW-1:0] cnt_q;
  logic             last;
  logic [AddrW:0]   src_addr;
  logic             src_ok;
  logic             wr_pend_q;
  logic [AddrW-1:0] wr_addr_q;
  logic             wr_src_q;

  // put arithmetic
  logic [ColNW-1:0]   tab_next [TabEntries];
  logic [ColNW-1:0]   col_n;
  logic [ColNW-1:0]   col_w;
  logic               line_feed;
  logic               wrap;
  logic               printable;
  logic [RowNW-1:0]   row_n;
  logic               put_scroll;
  logic [ColW-1:0]    put_col;
  logic [CurRowW-1:0] put_row;
  logic [ColW-1:0]    set_col;
  logic [CurRowW-1:0] set_row;
  logic               idx_ok;

  // next tab stop for every column value
  for (genvar c = 0; c < TabEntries; c++) begin : g_tab
    assign tab_next[c] = ColNW'(c + TAB_WIDTH - (c % TAB_WIDTH));
  end

  assign printable = (code_q >= CodePrintLo) && (code_q <= CodePrintHi);
  assign line_feed = (code_q == CodeLineFeed);

  always_comb begin
    col_n = ColNW'(col_q);
    if (code_q == CodeBackspace) begin
      if (col_q != '0) col_n = ColNW'(col_q) - ColNW'(1);
    end else if (code_q == CodeTab) begin
      col_n = tab_next[col_q];
    end else if ((code_q == CodeCarriage) || line_feed) begin
      col_n = '0;
    end else if (printable) begin
      col_n = ColNW'(col_q) + ColNW'(1);
    end
  end

  assign wrap       = (32'(col_n) >= COLUMNS);
  assign col_w      = wrap ? '0 : col_n;
  assign row_n      = RowNW'(row_q) + RowNW'(line_feed || wrap);
  assign put_scroll = (32'(row_n) >= ROWS);
  assign put_col    = ColW'(col_w);
  assign put_row    = put_scroll ? CurRowW'(ROWS - 1) : CurRowW'(row_n);

  assign set_col = (32'(column_q) > COLUMNS - 1) ? ColW'(COLUMNS - 1) : ColW'(column_q);
  assign set_row = (32'(row_in_q) > ROWS - 1) ? CurRowW'(ROWS - 1) : CurRowW'(row_in_q);
  assign idx_ok  = (32'(idx_q) < CellCount);

  // sweep addressing: during scroll, read one row below and write back later
  assign last     = (cnt_q == AddrW'(CellCount - 1));
  assign src_addr = {1'b0, cnt_q} + (AddrW + 1)'(COLUMNS);
  assign src_ok   = (32'(src_addr) < CellCount);

  always_comb begin
    if (cmd_i.shift) begin
      rd_addr = src_ok ? src_addr[AddrW-1:0] : cnt_q;
    end else begin
      rd_addr = AddrW'(idx_q);
    end
  end

  always_comb begin
    we = 1'b0;
    wa = cnt_q;
    wd = BlankCell;
    if (wr_pend_q) begin
      we = 1'b1;
      wa = wr_addr_q;
      wd = wr_src_q ? rd_q : BlankCell;
    end else if (cmd_i.fill) begin
      we = 1'b1;
    end else if (cmd_i.exec && (act_q == ACT_PUT) && printable) begin
      we = 1'b1;
      wa = cur_addr_q;
      wd = {back_q, fore_q, code_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[rd_addr];
  end

  // transaction fields, scroll write stage and read result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q    <= action_e'(action_i);
      code_q   <= char_code_i;
      back_q   <= back_color_i;
      fore_q   <= fore_color_i;
      column_q <= column_i;
      row_in_q <= row_i;
      idx_q    <= cell_index_i;
    end
    wr_addr_q <= cnt_q;
    wr_src_q  <= src_ok;
    if (cmd_i.locate) begin
      cell_data_q <= ((act_q == ACT_READ) && idx_ok) ? rd_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      cur_addr_q <= '0;
      cnt_q      <= '0;
      wr_pend_q  <= 1'b0;
    end else begin
      wr_pend_q <= cmd_i.shift;
      if (cmd_i.fill || cmd_i.shift) begin
        cnt_q <= last ? '0 : cnt_q + AddrW'(1);
      end
      if (cmd_i.exec) begin
        unique case (act_q)
          ACT_PUT: begin
            col_q <= put_col;
            row_q <= put_row;
          end
          ACT_CLEAR: begin
            col_q <= '0;
            row_q <= '0;
          end
          ACT_SET: begin
            col_q <= set_col;
            row_q <= set_row;
          end
          default: begin
            col_q <= col_q;
          end
        endcase
      end
      if (cmd_i.locate) begin
        cur_addr_q <= AddrW'(row_q * COLUMNS) + AddrW'(col_q);
      end
    end
  end

  assign sts_o.action = act_q;
  assign sts_o.scroll = put_scroll;
  assign sts_o.last   = last;

  assign cursor_location_o = LocW'(cur_addr_q);
  assign cell_data_o       = cell_data_q;

endmodule

FILE: hdl/text_console_cursor_scroll.sv
// ----------------------------------------------------------------------------
// Text console with cursor and scroll
// Character-cell terminal engine: screen store of attribute/character cells,
// a cursor, put character, read cell, clear screen and set cursor.
// ----------------------------------------------------------------------------
// Usage:
//   Present a transaction on the input ports with start high; it is taken at
//   the rising edge where start is high and busy is low. Fields not used by
//   the action are ignored.
//   Each transaction gives one result: done_o is high for one cycle with
//   cursor_location_o and cell_data_o valid; the receiver cannot stall it.
//   Put (no scroll), read and set cursor: the sequencer steps execute,
//   locate and report one per cycle, done_o marks report, and busy drops
//   the cycle after, so no new transaction is taken before the last is done.
//   Clear screen adds a blank fill of all COLUMNS*ROWS cells (one blank write
//   per cycle on the single store write port); a put that scrolls adds a
//   sweep over all cells and a drain step (one cell moved per cycle, read and
//   write port pipelined).
//   Reset: cursor goes to the top left, and a clearing pass writes blank to
//   all COLUMNS*ROWS cells, one per cycle, with busy high.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll #(
  parameter int COLUMNS   = tccs_pkg::DefColumns,
  parameter int ROWS      = tccs_pkg::DefRows,
  parameter int TAB_WIDTH = tccs_pkg::DefTabWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [tccs_pkg::ActionW-1:0]  action_i,
  input  logic [tccs_pkg::CharW-1:0]    char_code_i,
  input  logic [tccs_pkg::ColorW-1:0]   back_color_i,
  input  logic [tccs_pkg::ColorW-1:0]   fore_color_i,
  input  logic [tccs_pkg::ColumnW-1:0]  column_i,
  input  logic [tccs_pkg::RowW-1:0]     row_i,
  input  logic [tccs_pkg::CellIdxW-1:0] cell_index_i,
  output logic                          done_o,
  output logic [tccs_pkg::LocW-1:0]     cursor_location_o,
  output logic [tccs_pkg::CellW-1:0]    cell_data_o
);
  import tccs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  tccs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  tccs_dpath #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .action_i          (action_i),
    .char_code_i       (char_code_i),
    .back_color_i      (back_color_i),
    .fore_color_i      (fore_color_i),
    .column_i          (column_i),
    .row_i             (row_i),
    .cell_index_i      (cell_index_i),
    .cursor_location_o (cursor_location_o),
    .cell_data_o       (cell_data_o)
  );

  // an accepted transaction keeps the block busy until its result
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  // the result strobe comes only while busy and lasts one cycle
  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (busy && !cmd.load))
    else $error("result strobe outside a busy transaction");

  a_done_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy))
    else $error("result strobe longer than one cycle");

  // only one datapath command at a time
  a_sweep_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.fill, cmd.shift, cmd.exec, cmd.locate, cmd.load}))
    else $error("overlapping datapath commands");

endmodule
